### hw/rtl/ssht_pkg.sv
package ssht_pkg;

  // coordinate and derived widths
  localparam int CoordBits   = 20;
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits;
  localparam int DotBits     = ProdBits + 1;
  localparam int DistBits    = 42;
  localparam int RadiusBits  = 19;
  localparam int R2Bits      = 2 * RadiusBits;
  localparam int TBits       = 16;
  localparam int TProdBits   = TBits + 1 + DiffBits;
  localparam int DivStages   = TBits;
  localparam int InDataBits  = 184;
  localparam int OutDataBits = 48;

  typedef logic signed [DiffBits-1:0] diff_t;

  // item carried through the divider stages
  typedef struct packed {
    diff_t [2:0]         d;
    diff_t [2:0]         l;
    logic [DistBits-1:0] rem;
    logic [DistBits-1:0] den;
    logic [TBits-1:0]    t;
    logic                mid;
    logic [DistBits-1:0] d2f;
  } div_item_t;

  // one restoring division step: one quotient bit
  function automatic div_item_t div_step(input div_item_t x);
    logic [DistBits:0] sh;
    div_item_t         y;
    y  = x;
    sh = {x.rem, 1'b0};
    if (sh >= {1'b0, x.den}) begin
      y.rem = DistBits'(sh - {1'b0, x.den});
      y.t   = {x.t[TBits-2:0], 1'b1};
    end else begin
      y.rem = sh[DistBits-1:0];
      y.t   = {x.t[TBits-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

### hw/rtl/ssht_div.sv
module ssht_div import ssht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  div_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output div_item_t out_item_o
);

  logic [DivStages-1:0] v_q;
  logic [DivStages-1:0] adv;
  div_item_t            st_q [DivStages];
  div_item_t            st_d [DivStages];

  // per-stage advance: a stage moves when it is empty or its successor moves
  always_comb begin
    for (int k = DivStages - 1; k >= 0; k--) begin
      if (k == DivStages - 1) begin
        adv[k] = !v_q[k] || out_ready_i;
      end else begin
        adv[k] = !v_q[k] || adv[k+1];
      end
    end
  end

  // one quotient bit per stage
  always_comb begin
    st_d[0] = div_step(in_item_i);
    for (int k = 1; k < DivStages; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < DivStages; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivStages; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[DivStages-1];
  assign out_item_o  = st_q[DivStages-1];

  // back-pressure only when every stage is full and the output stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&v_q) && !out_ready_i))
    else $error("divider stalled with an empty stage");

  // a stalled result item is not dropped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("divider dropped an item");

  // the partial remainder stays below the divisor for interior projections
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.mid) |-> (out_item_o.rem < out_item_o.den))
    else $error("divider remainder out of range");

endmodule

### hw/rtl/segment_sphere_hit_test.sv
// pipeline: 3 front stages, 16 divider stages and 5 back stages
// throughput: one item per cycle while m_axis_tready keeps up; the
// 16-stage restoring divider and per-stage valid bits let a new item
// enter every cycle unless a full pipeline is stalled by the output
// reset: asynchronous active low, clears all valid bits and sets radius to 0
module segment_sphere_hit_test import ssht_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [RadiusBits-1:0]  cfg_data,       // sphere_radius
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [InDataBits-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata,   // dist_sq
  output logic                   m_axis_tuser    // hit
);

  // radius squared, computed on write
  logic [R2Bits-1:0] r2_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= '0;
    end else if (cfg_valid) begin
      r2_q <= R2Bits'(cfg_data) * R2Bits'(cfg_data);
    end
  end

  // front pipeline control
  logic [2:0] fv_q;
  logic [2:0] fadv;
  logic       div_in_ready;

  always_comb begin
    fadv[2] = !fv_q[2] || div_in_ready;
    fadv[1] = !fv_q[1] || fadv[2];
    fadv[0] = !fv_q[0] || fadv[1];
  end

  assign s_axis_tready = fadv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      if (fadv[0]) fv_q[0] <= s_axis_tvalid;
      if (fadv[1]) fv_q[1] <= fv_q[0];
      if (fadv[2]) fv_q[2] <= fv_q[1];
    end
  end

  // front stage 0: differences
  diff_t [2:0] d0_d, l0_d, pe0_d;
  diff_t [2:0] d0_q, l0_q, pe0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [CoordBits-1:0] p, s, e;
      p = s_axis_tdata[CoordBits*i +: CoordBits];
      s = s_axis_tdata[CoordBits*(3+i) +: CoordBits];
      e = s_axis_tdata[CoordBits*(6+i) +: CoordBits];
      d0_d[i]  = $signed({p[CoordBits-1], p}) - $signed({s[CoordBits-1], s});
      l0_d[i]  = $signed({e[CoordBits-1], e}) - $signed({s[CoordBits-1], s});
      pe0_d[i] = $signed({p[CoordBits-1], p}) - $signed({e[CoordBits-1], e});
    end
  end

  always_ff @(posedge clk_i) begin
    if (fadv[0]) begin
      d0_q  <= d0_d;
      l0_q  <= l0_d;
      pe0_q <= pe0_d;
    end
  end

  // front stage 1: products
  logic signed [ProdBits-1:0] dl1_q [3];
  logic signed [ProdBits-1:0] ll1_q [3];
  logic signed [ProdBits-1:0] dd1_q [3];
  logic signed [ProdBits-1:0] ee1_q [3];
  diff_t [2:0]                d1_q, l1_q;

  always_ff @(posedge clk_i) begin
    if (fadv[1]) begin
      for (int i = 0; i < 3; i++) begin
        dl1_q[i] <= $signed(d0_q[i]) * $signed(l0_q[i]);
        ll1_q[i] <= $signed(l0_q[i]) * $signed(l0_q[i]);
        dd1_q[i] <= $signed(d0_q[i]) * $signed(d0_q[i]);
        ee1_q[i] <= $signed(pe0_q[i]) * $signed(pe0_q[i]);
      end
      d1_q <= d0_q;
      l1_q <= l0_q;
    end
  end

  // front stage 2: sums and case selection
  div_item_t div_in_d, div_in_q;

  always_comb begin
    logic signed [DotBits-1:0] dot;
    logic [DistBits-1:0]       len2, d2s, d2e;
    dot  = DotBits'(dl1_q[0]) + DotBits'(dl1_q[1]) + DotBits'(dl1_q[2]);
    len2 = DistBits'(ll1_q[0]) + DistBits'(ll1_q[1]) + DistBits'(ll1_q[2]);
    d2s  = DistBits'(dd1_q[0]) + DistBits'(dd1_q[1]) + DistBits'(dd1_q[2]);
    d2e  = DistBits'(ee1_q[0]) + DistBits'(ee1_q[1]) + DistBits'(ee1_q[2]);
    div_in_d.d   = d1_q;
    div_in_d.l   = l1_q;
    div_in_d.rem = dot[DistBits-1:0];
    div_in_d.den = len2;
    div_in_d.t   = '0;
    div_in_d.mid = (dot > 0) && ($signed({1'b0, len2}) > dot);
    div_in_d.d2f = (dot > 0) ? d2e : d2s;
  end

  always_ff @(posedge clk_i) begin
    if (fadv[2]) begin
      div_in_q <= div_in_d;
    end
  end

  // pipelined divider
  logic      div_out_valid;
  logic      div_out_ready;
  div_item_t div_out;

  ssht_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fv_q[2]),
    .in_ready_o  (div_in_ready),
    .in_item_i   (div_in_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (div_out_ready),
    .out_item_o  (div_out)
  );

  // back pipeline control
  logic [4:0] bv_q;
  logic [4:0] badv;

  always_comb begin
    badv[4] = !bv_q[4] || m_axis_tready;
    for (int k = 3; k >= 0; k--) begin
      badv[k] = !bv_q[k] || badv[k+1];
    end
  end

  assign div_out_ready = badv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      if (badv[0]) bv_q[0] <= div_out_valid;
      for (int k = 1; k < 5; k++) begin
        if (badv[k]) bv_q[k] <= bv_q[k-1];
      end
    end
  end

  // back stage 0: t * L
  logic signed [TProdBits-1:0] tl0_q [3];
  diff_t [2:0]                 bd0_q;
  logic                        mid0_q, mid1_q, mid2_q;
  logic [DistBits-1:0]         d2f0_q, d2f1_q, d2f2_q;

  always_ff @(posedge clk_i) begin
    if (badv[0]) begin
      for (int i = 0; i < 3; i++) begin
        tl0_q[i] <= $signed({1'b0, div_out.t}) * $signed(div_out.l[i]);
      end
      bd0_q  <= div_out.d;
      mid0_q <= div_out.mid;
      d2f0_q <= div_out.d2f;
    end
  end

  // back stage 1: P - C = D - floor(t * L / 2^T)
  diff_t [2:0] cd1_q;

  always_ff @(posedge clk_i) begin
    if (badv[1]) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [TProdBits-TBits-1:0] fl;
        logic signed [DiffBits+1:0]        df;
        fl = tl0_q[i][TProdBits-1:TBits];
        df = (DiffBits+2)'(bd0_q[i]) - (DiffBits+2)'(fl);
        cd1_q[i] <= df[DiffBits-1:0];
      end
      mid1_q <= mid0_q;
      d2f1_q <= d2f0_q;
    end
  end

  // back stage 2: squares
  logic signed [ProdBits-1:0] sq2_q [3];

  always_ff @(posedge clk_i) begin
    if (badv[2]) begin
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= $signed(cd1_q[i]) * $signed(cd1_q[i]);
      end
      mid2_q <= mid1_q;
      d2f2_q <= d2f1_q;
    end
  end

  // back stage 3: sum and select
  logic [DistBits-1:0] d2_3_q;

  always_ff @(posedge clk_i) begin
    if (badv[3]) begin
      if (mid2_q) begin
        d2_3_q <= DistBits'(sq2_q[0]) + DistBits'(sq2_q[1]) + DistBits'(sq2_q[2]);
      end else begin
        d2_3_q <= d2f2_q;
      end
    end
  end

  // output register: radius compare
  logic [DistBits-1:0] dist_q;
  logic                hit_q;

  always_ff @(posedge clk_i) begin
    if (badv[4]) begin
      dist_q <= d2_3_q;
      hit_q  <= (d2_3_q <= DistBits'(r2_q));
    end
  end

  assign m_axis_tvalid = bv_q[4];
  assign m_axis_tdata  = OutDataBits'(dist_q);
  assign m_axis_tuser  = hit_q;

  // radius square follows the last write
  a_r2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |=> (r2_q == R2Bits'($past(cfg_data)) * R2Bits'($past(cfg_data))))
    else $error("radius square not updated");

  // input stalls only while the first stage holds an item
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> fv_q[0])
    else $error("input stalled with an empty first stage");

  // squared distance never exceeds three times the squared coordinate span
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (dist_q <= DistBits'(3) * (DistBits'(1) << (2 * CoordBits))))
    else $error("squared distance out of range");

endmodule

### tb/tb.sv
module tb;
  import ssht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCycles = 400000;

  typedef struct packed {
    logic        hit;
    logic [41:0] dist_sq;
  } hit_res_t;

  typedef struct {
    logic signed [19:0] c[9];
    logic               chk;
    hit_res_t           res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [RadiusBits-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  logic [18:0]  radius_q = '0;
  hit_res_t     pending_hits[$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           no_idle = 1'b0;
  stim_row_t    rows[$];

  segment_sphere_hit_test dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // floor division by 2^16 of a signed product
  function automatic longint floor16(longint p);
    longint one;
    one = 64'sd65536;
    if (p >= 0) return p / one;
    return -((-p + one - 1) / one);
  endfunction

  // closest point on the segment and squared distance
  function automatic hit_res_t seg_sphere_dist(logic signed [19:0] c[9], logic [18:0] r);
    longint p[3], s[3], e[3], ln[3], cp[3];
    longint dot, len2, d, t;
    longint unsigned d2, r2;
    hit_res_t o;
    dot = 0; len2 = 0; d2 = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = c[i]; s[i] = c[3+i]; e[i] = c[6+i];
      ln[i] = e[i] - s[i];
      dot += (p[i] - s[i]) * ln[i];
      len2 += ln[i] * ln[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (dot <= 0) cp[i] = s[i];
      else if (len2 <= dot) cp[i] = e[i];
      else begin
        t = (dot <<< 16) / len2;
        cp[i] = s[i] + floor16(t * ln[i]);
      end
      d = p[i] - cp[i];
      d2 += d * d;
    end
    r2 = longint'(r) * longint'(r);
    o.hit = (d2 <= r2);
    o.dist_sq = d2[41:0];
    return o;
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    hit_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", m_axis_tdata);
      end else begin
        want = pending_hits.pop_front();
        if (m_axis_tuser !== want.hit || m_axis_tdata !== {6'b0, want.dist_sq}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %b dist %h, got hit %b dist %h",
                     want.hit, want.dist_sq, m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
  end

  task automatic write_radius(logic [18:0] r);
    cfg_data  <= r;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    radius_q = r;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_query(logic signed [19:0] c[9]);
    logic [InDataBits-1:0] pk;
    pk = '0;
    for (int i = 0; i < 9; i++) pk[i*20 +: 20] = c[i];
    while (!no_idle && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= pk;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_hits.push_back(seg_sphere_dist(c, radius_q));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic stim_row_t mk(int v[9], logic chk, hit_res_t r);
    stim_row_t x;
    for (int i = 0; i < 9; i++) x.c[i] = 20'(v[i]);
    x.chk = chk; x.res = r;
    return x;
  endfunction

  // coordinate either full range or clustered near a base
  function automatic logic signed [19:0] rnd_coord(int base, bit near);
    if (!near) return 20'($urandom);
    return 20'(base + $signed($urandom_range(2000)) - 1000);
  endfunction

  initial begin
    logic signed [19:0] q[9];
    stim_row_t r;
    hit_res_t got;
    int b;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: known results at reset radius 0
    rows.push_back(mk('{0,0,0,0,0,0,0,0,0}, 1, '{1'b1, 42'd0}));
    rows.push_back(mk('{16,0,0,0,0,0,0,0,0}, 1, '{1'b0, 42'd256}));
    rows.push_back(mk('{-524288,-524288,-524288,524287,524287,524287,524287,524287,524287},
                      1, '{1'b0, 42'(3 * 64'd1099509530625)}));
    rows.push_back(mk('{524287,524287,524287,-524288,-524288,-524288,-524288,-524288,
                        -524288}, 1, '{1'b0, 42'(3 * 64'd1099509530625)}));
    rows.push_back(mk('{-100,0,0,0,0,0,100,0,0}, 1, '{1'b0, 42'd10000}));
    rows.push_back(mk('{300,0,0,0,0,0,100,0,0}, 1, '{1'b0, 42'd40000}));
    rows.push_back(mk('{50,30,0,0,0,0,100,0,0}, 1, '{1'b0, 42'd900}));
    rows.push_back(mk('{5,7,9,5,7,9,5,7,9}, 1, '{1'b1, 42'd0}));
    rows.push_back(mk('{33,-17,91,-40,22,-5,77,-60,13}, 0, '0));
    rows.push_back(mk('{-524288,524287,0,524287,-524288,0,-524288,524287,0}, 0, '0));
    rows.push_back(mk('{1,1,1,-3,-7,2,9,11,-4}, 0, '0));
    foreach (rows[k]) begin
      r = rows[k];
      if (r.chk) begin
        got = seg_sphere_dist(r.c, radius_q);
        if (got !== r.res) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d: exp %h got %h", k, r.res, got);
        end
      end
      send_query(r.c);
    end
    drain();

    // random phases over several radius settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_radius(19'h7ffff);
        1: write_radius(19'd0);
        2: write_radius(19'd1);
        default: write_radius(19'($urandom));
      endcase
      no_idle = (ph == 3);
      for (int n = 0; n < 330; n++) begin
        b = $signed(20'($urandom));
        for (int i = 0; i < 9; i++) q[i] = rnd_coord(b, $urandom_range(3) != 0);
        if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) q[6+i] = q[3+i];
        send_query(q);
      end
      drain();
    end

    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/ssht_pkg.sv
hw/rtl/ssht_div.sv
hw/rtl/segment_sphere_hit_test.sv
tb/tb.sv
